[design/ets_pkg.sv]
`timescale 1ns / 1ps
package ets_pkg;

  // Position counter: width of the offset field and its saturation limit
  localparam int PosBits  = 16;
  localparam int PosWidth = 16;
  localparam logic [PosWidth-1:0] PosLimit =
    (PosBits >= 16) ? {PosWidth{1'b1}} : PosWidth'((32'd1 << PosBits) - 32'd1);

  // Most tokens one input word can produce
  localparam int MaxTok   = 3;
  localparam int CntWidth = $clog2(MaxTok + 1);

  // Bundle queue between scanner and emitter
  localparam int QDepth   = 4;
  localparam int QPtrBits = $clog2(QDepth);

  typedef enum logic [1:0] {
    KIND_PUNCT = 2'd0,
    KIND_OP    = 2'd1,
    KIND_WORD  = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [PosWidth-1:0] start_pos;
    logic [PosWidth-1:0] token_len;
    logic [7:0]          first_byte;
  } token_t;

  // All tokens caused by one input word, slot 0 first
  typedef struct packed {
    logic [CntWidth-1:0] cnt;
    token_t [MaxTok-1:0] tok;
  } bundle_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[design/expression_token_scanner_core.sv]
`timescale 1ns / 1ps
// Expression token scanner.
// Input stream: one text byte per word on s_axis (tdata = byte, tlast marks
// the final byte). A zero byte or tlast ends the text and yields an end token.
// Output stream: one token per word on m_axis; tuser carries the token kind,
// tdata its start offset, length and first byte, tlast marks the last token
// produced by one input byte (a byte yields zero to three tokens).
// A token completed by an accepted byte leaves the block by way of the bundle
// queue and then the emitter register.
// Throughput: one input byte per cycle while each byte yields at most one
// token and m_axis_tready is high; the emitter then sends one token per cycle,
// so the four-bundle queue absorbs the burst from a byte that completes
// several tokens. Bytes that produce nothing never enter the queue.
// Reset clears the scanner to idle at offset zero and empties the queue.
// When the receiver stalls, the emitter holds its token and the queue fills;
// s_axis_tready drops only once the queue is full.
module expression_token_scanner_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] start_pos, [31:16] token_len, [39:32] first_byte
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);
  import ets_pkg::*;

  bundle_t   scan_bundle;
  bundle_t   q_head;
  q_status_t q_status;
  logic      in_fire;
  logic      push;
  logic      pop;
  token_t    out_tok;

  assign s_axis_tready = !q_status.full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign push          = in_fire && (scan_bundle.cnt != '0);

  ets_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .ch_i      (s_axis_tdata),
    .last_i    (s_axis_tlast),
    .bundle_o  (scan_bundle)
  );

  ets_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (scan_bundle),
    .pop_i    (pop),
    .rdata_o  (q_head),
    .status_o (q_status)
  );

  ets_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .q_empty_i   (q_status.empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tok_o   (out_tok),
    .out_end_o   (m_axis_tlast)
  );

  // Pack token fields onto the output stream
  assign m_axis_tdata = {out_tok.first_byte, out_tok.token_len, out_tok.start_pos};
  assign m_axis_tuser = out_tok.kind;

endmodule

[design/ets_scan.sv]
`timescale 1ns / 1ps
module ets_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  logic [7:0]         ch_i,
  input  logic               last_i,
  output ets_pkg::bundle_t   bundle_o
);
  import ets_pkg::*;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChLt    = 8'h3c;
  localparam logic [7:0] ChGt    = 8'h3e;
  localparam logic [7:0] ChEq    = 8'h3d;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChBar   = 8'h7c;
  localparam logic [7:0] ChAmp   = 8'h26;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_OP      = 2'd1,
    MODE_WORD    = 2'd2,
    MODE_COMMENT = 2'd3
  } mode_e;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChTab) || (c == ChSpace) || (c == ChLf);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == 8'h28) || (c == 8'h5b) || (c == 8'h7b) || (c == 8'h2c) ||
           (c == 8'h7d) || (c == 8'h5d) || (c == 8'h29) || (c == 8'h27) ||
           (c == 8'h22) || (c == 8'h2d) || (c == 8'h2e);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == ChColon) || (c == ChPlus) || (c == ChLt) || (c == ChGt) ||
           (c == ChEq) || (c == ChBang) || (c == ChStar) || (c == ChBar) ||
           (c == ChAmp) || (c == ChSlash);
  endfunction

  function automatic logic pairs_with(input logic [7:0] f, input logic [7:0] c);
    logic r;
    case (f)
      ChColon:                            r = (c == ChLt);
      ChPlus, ChLt, ChGt, ChEq, ChBang:   r = (c == ChEq);
      ChStar:                             r = (c == ChStar);
      ChBar:                              r = (c == ChBar);
      ChAmp:                              r = (c == ChAmp);
      default:                            r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic token_t mk_tok(input kind_e k, input logic [PosWidth-1:0] s,
                                    input logic [PosWidth-1:0] l, input logic [7:0] f);
    token_t t;
    t.kind       = k;
    t.start_pos  = s;
    t.token_len  = l;
    t.first_byte = f;
    return t;
  endfunction

  mode_e               mode_q, mode_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [PosWidth-1:0] pstart_q, pstart_d;
  logic [7:0]          pfirst_q, pfirst_d;
  logic                star_q, star_d;

  // Next scanner state and the tokens this word produces
  always_comb begin
    token_t [MaxTok-1:0] tok;
    logic [CntWidth-1:0] n;
    logic                begin_tok;
    logic                do_flush;
    logic [PosWidth-1:0] fl_pos;

    tok       = '0;
    n         = '0;
    begin_tok = 1'b0;
    mode_d    = mode_q;
    pos_d     = pos_q;
    pstart_d  = pstart_q;
    pfirst_d  = pfirst_q;
    star_d    = star_q;
    do_flush  = 1'b0;
    fl_pos    = pos_q;

    if (ch_i == ChNul) begin
      do_flush = 1'b1;
      fl_pos   = pos_q;
    end else begin
      case (mode_q)
        MODE_OP: begin
          if (pfirst_q == ChSlash && ch_i == ChStar) begin
            mode_d = MODE_COMMENT;
            star_d = 1'b1;
          end else if (pairs_with(pfirst_q, ch_i)) begin
            tok[n] = mk_tok(KIND_OP, pstart_q, PosWidth'(2), pfirst_q);
            n      = n + 1'b1;
            mode_d = MODE_IDLE;
          end else begin
            tok[n]    = mk_tok(KIND_OP, pstart_q, PosWidth'(1), pfirst_q);
            n         = n + 1'b1;
            begin_tok = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_space(ch_i) || is_punct(ch_i) || is_op(ch_i)) begin
            tok[n]    = mk_tok(KIND_WORD, pstart_q, pos_q - pstart_q, pfirst_q);
            n         = n + 1'b1;
            begin_tok = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (star_q && ch_i == ChSlash) begin
            mode_d = MODE_IDLE;
            star_d = 1'b0;
          end else begin
            star_d = (ch_i == ChStar);
          end
        end
        default: begin_tok = 1'b1;
      endcase

      // Start of a new token at this byte
      if (begin_tok) begin
        if (is_space(ch_i)) begin
          mode_d = MODE_IDLE;
        end else if (is_punct(ch_i)) begin
          tok[n] = mk_tok(KIND_PUNCT, pos_q, PosWidth'(1), ch_i);
          n      = n + 1'b1;
          mode_d = MODE_IDLE;
        end else begin
          mode_d   = is_op(ch_i) ? MODE_OP : MODE_WORD;
          pstart_d = pos_q;
          pfirst_d = ch_i;
        end
      end

      pos_d    = (pos_q >= PosLimit) ? PosLimit : pos_q + 1'b1;
      do_flush = last_i;
      fl_pos   = pos_d;
    end

    // End of text: emit the pending token, the end marker, then restart
    if (do_flush) begin
      if (mode_d == MODE_OP) begin
        tok[n] = mk_tok(KIND_OP, pstart_d, PosWidth'(1), pfirst_d);
        n      = n + 1'b1;
      end else if (mode_d == MODE_WORD) begin
        tok[n] = mk_tok(KIND_WORD, pstart_d, fl_pos - pstart_d, pfirst_d);
        n      = n + 1'b1;
      end
      tok[n]   = mk_tok(KIND_END, fl_pos, '0, 8'h00);
      n        = n + 1'b1;
      mode_d   = MODE_IDLE;
      pos_d    = '0;
      pstart_d = '0;
      pfirst_d = '0;
      star_d   = 1'b0;
    end

    bundle_o.cnt = n;
    bundle_o.tok = tok;
  end

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= '0;
      pstart_q <= '0;
      pfirst_q <= '0;
      star_q   <= 1'b0;
    end else if (in_fire_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      pstart_q <= pstart_d;
      pfirst_q <= pfirst_d;
      star_q   <= star_d;
    end
  end

endmodule

[design/ets_fifo.sv]
`timescale 1ns / 1ps
module ets_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ets_pkg::bundle_t    wdata_i,
  input  logic                pop_i,
  output ets_pkg::bundle_t    rdata_o,
  output ets_pkg::q_status_t  status_o
);
  import ets_pkg::*;

  bundle_t             mem_q [QDepth];
  logic [QPtrBits-1:0] wptr_q, rptr_q;
  logic [QPtrBits:0]   cnt_q;

  assign status_o.full  = (cnt_q == (QPtrBits+1)'(QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign rdata_o        = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (QPtrBits+1)'(push_i) - (QPtrBits+1)'(pop_i);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full |-> !push_i || pop_i)
    else $error("bundle queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.empty |-> !pop_i)
    else $error("bundle queue underflow");
  a_level_tracks_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wptr_q - rptr_q) == cnt_q[QPtrBits-1:0])
    else $error("bundle queue level out of step with pointers");
`endif

endmodule

[design/ets_emit.sv]
`timescale 1ns / 1ps
module ets_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ets_pkg::bundle_t    head_i,
  input  logic                q_empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ets_pkg::token_t     out_tok_o,
  output logic                out_end_o
);
  import ets_pkg::*;

  bundle_t             cur_q;
  logic [CntWidth-1:0] idx_q;
  logic                valid_q;
  logic                fire;
  logic                last_slot;
  logic                load;

  assign fire        = valid_q && out_ready_i;
  assign last_slot   = (idx_q == cur_q.cnt - 1'b1);
  assign load        = !valid_q || (fire && last_slot);
  assign pop_o       = load && !q_empty_i;
  assign out_valid_o = valid_q;
  assign out_tok_o   = cur_q.tok[idx_q[$clog2(MaxTok)-1:0]];
  assign out_end_o   = last_slot;

  // Current bundle and slot index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= !q_empty_i;
      idx_q   <= '0;
    end else if (fire) begin
      idx_q   <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q < cur_q.cnt) && (cur_q.cnt != '0))
    else $error("emitter slot index past bundle size");
  a_end_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && cur_q.tok[idx_q[$clog2(MaxTok)-1:0]].kind == KIND_END) |-> last_slot)
    else $error("end marker not the last token of its word");
`endif

endmodule
